FILE: design/tscf_pkg.sv
package tscf_pkg;

    localparam int unsigned NUM_DIGITS = 6;
    localparam int unsigned QDEPTH     = 4;
    localparam int unsigned QAW        = $clog2(QDEPTH);

    localparam logic [7:0] NL_BYTE    = 8'd10;
    localparam logic [7:0] TAB_BYTE   = 8'd9;
    localparam logic [7:0] DEL_BYTE   = 8'd127;
    localparam logic [7:0] SPACE_BYTE = 8'd32;
    localparam logic [7:0] ZERO_CHAR  = 8'd48;
    localparam logic [7:0] CARET_CHAR = 8'd94;
    localparam logic [7:0] DOLLAR     = 8'd36;
    localparam logic [7:0] I_CHAR     = 8'd73;
    localparam logic [7:0] QMARK      = 8'd63;
    localparam logic [7:0] CTRL_OFS   = 8'd64;
    localparam logic [7:0] CTRL_LIMIT = 8'd32;

    localparam logic [2:0] REG_NUMBER_MODE = 3'd0;
    localparam logic [2:0] REG_SQUEEZE     = 3'd1;
    localparam logic [2:0] REG_SHOW_TABS   = 3'd2;
    localparam logic [2:0] REG_SHOW_ENDS   = 3'd3;
    localparam logic [2:0] REG_SHOW_NONPR  = 3'd4;

    localparam logic [1:0] NUM_OFF     = 2'd0;
    localparam logic [1:0] NUM_ALL     = 2'd1;

    // position of the byte being emitted within one transaction's run
    localparam logic [3:0] POS_FIRST = 4'd0;
    localparam logic [3:0] POS_UNITS = 4'd5;
    localparam logic [3:0] POS_TAB   = 4'd6;
    localparam logic [3:0] POS_PRE   = 4'd7;
    localparam logic [3:0] POS_FIN   = 4'd8;

    typedef logic [NUM_DIGITS-1:0][3:0] t_bcd;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       squeeze_blank;
        logic       show_tabs;
        logic       show_ends;
        logic       show_nonprinting;
    } t_cfg;

    typedef struct packed {
        logic       num;
        t_bcd       digits;
        logic       pre;
        logic [7:0] pre_byte;
        logic [7:0] fin_byte;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: design/tscf_front.sv
module tscf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tscf_pkg::t_cfg i_cfg,
    input  logic           i_accept,
    input  logic [7:0]     i_in_byte,
    input  logic           i_file_start,
    output logic           o_push,
    output tscf_pkg::t_job o_job
);
    import tscf_pkg::*;

    logic [7:0] r_prev;
    logic       r_als;
    logic [1:0] r_br;
    t_bcd       r_line;

    logic [7:0] n_prev;
    logic       n_als;
    logic [1:0] n_br;
    t_bcd       n_line;

    logic [7:0] prev_eff;
    logic       als_eff;
    logic [1:0] br_eff;
    logic [1:0] br_new;
    logic       drop;
    logic       number_it;
    logic       pre;
    logic [7:0] pre_byte;
    logic [7:0] fin_byte;
    logic       all_nines;
    logic       carry;
    t_bcd       line_inc;

    always_comb begin
        prev_eff = i_file_start ? NL_BYTE : r_prev;
        als_eff  = i_file_start ? 1'b1 : r_als;
        br_eff   = i_file_start ? 2'd0 : r_br;

        br_new = br_eff;
        drop   = 1'b0;
        if (i_cfg.squeeze_blank) begin
            if (i_in_byte == NL_BYTE && prev_eff == NL_BYTE) begin
                br_new = (br_eff < 2'd2) ? br_eff + 2'd1 : 2'd2;
            end else begin
                br_new = 2'd0;
            end
            drop = br_new > 2'd1;
        end

        if (i_cfg.number_mode == NUM_OFF) begin
            number_it = 1'b0;
        end else if (i_cfg.number_mode == NUM_ALL) begin
            number_it = als_eff;
        end else begin
            number_it = als_eff && (i_in_byte != NL_BYTE);
        end

        pre      = 1'b0;
        pre_byte = CARET_CHAR;
        fin_byte = i_in_byte;
        if (i_cfg.show_tabs && i_in_byte == TAB_BYTE) begin
            pre      = 1'b1;
            fin_byte = I_CHAR;
        end else if (i_cfg.show_ends && i_in_byte == NL_BYTE) begin
            pre      = 1'b1;
            pre_byte = DOLLAR;
        end else if (i_cfg.show_nonprinting && (i_in_byte < TAB_BYTE ||
                     (i_in_byte > NL_BYTE && i_in_byte < CTRL_LIMIT))) begin
            pre      = 1'b1;
            fin_byte = i_in_byte + CTRL_OFS;
        end else if (i_cfg.show_nonprinting && i_in_byte == DEL_BYTE) begin
            pre      = 1'b1;
            fin_byte = QMARK;
        end
    end

    // saturating BCD increment of the line counter
    always_comb begin
        all_nines = 1'b1;
        carry     = 1'b1;
        line_inc  = r_line;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_line[i] != 4'd9) begin
                all_nines = 1'b0;
            end
            if (carry) begin
                if (r_line[i] == 4'd9) begin
                    line_inc[i] = 4'd0;
                end else begin
                    line_inc[i] = r_line[i] + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
    end

    always_comb begin
        n_prev = r_prev;
        n_als  = r_als;
        n_br   = r_br;
        n_line = r_line;
        if (i_accept) begin
            n_br = br_new;
            if (drop) begin
                n_prev = prev_eff;
                n_als  = als_eff;
            end else begin
                n_prev = fin_byte;
                n_als  = (fin_byte == NL_BYTE);
                if (number_it && !all_nines) begin
                    n_line = line_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= NL_BYTE;
            r_als  <= 1'b1;
            r_br   <= 2'd0;
            r_line <= t_bcd'(1);
        end else begin
            r_prev <= n_prev;
            r_als  <= n_als;
            r_br   <= n_br;
            r_line <= n_line;
        end
    end

    assign o_push         = i_accept && !drop;
    assign o_job.num      = number_it;
    assign o_job.digits   = r_line;
    assign o_job.pre      = pre;
    assign o_job.pre_byte = pre_byte;
    assign o_job.fin_byte = fin_byte;

endmodule

FILE: design/tscf_queue.sv
module tscf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tscf_pkg::t_job    i_job,
    input  logic              i_pop,
    output tscf_pkg::t_job    o_job,
    output tscf_pkg::t_q_stat o_stat
);
    import tscf_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QAW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_job        = r_mem[r_rptr];
    assign o_stat.full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

FILE: design/tscf_back.sv
module tscf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tscf_pkg::t_job    i_job,
    input  tscf_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_last_of_run
);
    import tscf_pkg::*;

    logic       r_busy;
    t_job       r_job;
    logic [3:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic                  can_load;
    logic                  at_fin;
    logic [3:0]            start_idx;
    logic [3:0]            next_idx;
    logic [7:0]            sel_byte;
    logic [NUM_DIGITS-1:0] blank;
    logic                  zero_so_far;
    logic [3:0]            digit;

    assign can_load = !r_out_valid || !i_out_stall;
    assign at_fin   = (r_idx == POS_FIN);
    assign o_pop    = !i_q_stat.empty && (!r_busy || (can_load && at_fin));

    always_comb begin
        if (i_job.num) begin
            start_idx = POS_FIRST;
        end else if (i_job.pre) begin
            start_idx = POS_PRE;
        end else begin
            start_idx = POS_FIN;
        end
        if (r_idx == POS_TAB) begin
            next_idx = r_job.pre ? POS_PRE : POS_FIN;
        end else begin
            next_idx = r_idx + 4'd1;
        end
    end

    // leading zeros of the counter show as spaces, units digit always printed
    always_comb begin
        zero_so_far = 1'b1;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            zero_so_far = zero_so_far && (r_job.digits[NUM_DIGITS-1-k] == 4'd0);
            blank[k]    = zero_so_far && (k < NUM_DIGITS-1);
        end
    end

    always_comb begin
        digit    = r_job.digits[POS_UNITS[2:0] - r_idx[2:0]];
        sel_byte = r_job.fin_byte;
        unique case (r_idx)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, POS_UNITS: begin
                sel_byte = blank[r_idx[2:0]] ? SPACE_BYTE : (ZERO_CHAR | {4'd0, digit});
            end
            POS_TAB: sel_byte = TAB_BYTE;
            POS_PRE: sel_byte = r_job.pre_byte;
            default: sel_byte = r_job.fin_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (can_load && r_busy && at_fin) begin
                r_busy <= 1'b0;
            end
            if (can_load) begin
                r_out_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_idx <= start_idx;
        end else if (can_load && r_busy && !at_fin) begin
            r_idx <= next_idx;
        end
        if (can_load && r_busy) begin
            r_out_byte <= sel_byte;
            r_out_last <= at_fin;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

endmodule

FILE: design/text_stream_cat_filter.sv
// channel  | handshake                   | payload
// ---------+-----------------------------+---------------------------------
// input    | i_in_valid / o_in_stall     | i_in_byte, i_file_start
// output   | o_out_valid / i_out_stall   | o_out_byte, o_last_of_run
// config   | i_cfg_we                    | i_cfg_index, i_cfg_data
//
// One input transaction is taken per cycle while the 4-entry job queue has room.
// Each transaction yields 0 to 9 output bytes (a squeezed newline yields none),
// one per cycle from the back end while the output is not stalled.
// Synchronous active-low reset clears state; line counter restarts at 1.
// An output stall holds the output register and backs up into the queue.
module text_stream_cat_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [1:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_file_start,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);
    import tscf_pkg::*;

    t_cfg    r_cfg;
    t_job    w_front_job;
    t_job    w_back_job;
    t_q_stat w_q_stat;
    logic    w_accept;
    logic    w_push;
    logic    w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_NUMBER_MODE: r_cfg.number_mode      <= i_cfg_data;
                REG_SQUEEZE:     r_cfg.squeeze_blank    <= i_cfg_data[0];
                REG_SHOW_TABS:   r_cfg.show_tabs        <= i_cfg_data[0];
                REG_SHOW_ENDS:   r_cfg.show_ends        <= i_cfg_data[0];
                REG_SHOW_NONPR:  r_cfg.show_nonprinting <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = w_q_stat.full;
    assign w_accept   = i_in_valid && !w_q_stat.full;

    tscf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (w_accept),
        .i_in_byte    (i_in_byte),
        .i_file_start (i_file_start),
        .o_push       (w_push),
        .o_job        (w_front_job)
    );

    tscf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_job   (w_back_job),
        .o_stat  (w_q_stat)
    );

    tscf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (w_back_job),
        .i_q_stat      (w_q_stat),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("job popped from empty queue");

    a_run_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_of_run) |=> o_out_valid)
        else $error("gap inside an output run");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

endmodule
